>>> src/gld_pkg.sv
// Package for the Gregorian to lunar date converter: constants, ROM and helper tables.
package gld_pkg;

	// Calendar anchors.
	localparam int BASE_YEAR       = 1921;
	localparam int BASE_OFFSET     = 38;
	localparam int DAYS_PER_YEAR   = 365;
	localparam int LONG_YEAR_MIN   = 4095;
	localparam int SHORT_MONTH     = 29;
	localparam int ROM_YEARS       = 100;
	localparam int TABLE_YEARS_DEF = 100;

	// Field widths.
	localparam int YEAR_W  = 11;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int IDX4_W  = 4;
	localparam int ENTRY_W = 20;
	localparam int COUNT_W = 22;
	localparam int WALK_W  = 16;
	localparam int ROM_IDX_W = 8;

	// Stem and branch of the first table year: (1921 - 4) mod 10 and mod 12.
	localparam logic [IDX4_W-1:0] STEM_BASE   = 4'd7;
	localparam logic [IDX4_W-1:0] BRANCH_BASE = 4'd9;
	localparam logic [IDX4_W-1:0] STEM_LAST   = 4'd9;
	localparam logic [IDX4_W-1:0] BRANCH_LAST = 4'd11;

	// Month bit positions of a 12-month and a 13-month year.
	localparam logic [3:0] TOP_SHORT = 4'd11;
	localparam logic [3:0] TOP_LONG  = 4'd12;

	// Day of year before the first of each Gregorian month (non-leap).
	function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Per-year lunar month masks; bits 19..16 of a long year name the leap month.
	function automatic logic [ENTRY_W-1:0] lunar_rom(input logic [ROM_IDX_W-1:0] i);
		logic [ENTRY_W-1:0] r;
		case (i)
			8'd0:  r = 20'd2635;   8'd1:  r = 20'd333387; 8'd2:  r = 20'd1701;
			8'd3:  r = 20'd1748;   8'd4:  r = 20'd267701; 8'd5:  r = 20'd694;
			8'd6:  r = 20'd2391;   8'd7:  r = 20'd133423; 8'd8:  r = 20'd1175;
			8'd9:  r = 20'd396438; 8'd10: r = 20'd3402;   8'd11: r = 20'd3749;
			8'd12: r = 20'd331177; 8'd13: r = 20'd1453;   8'd14: r = 20'd694;
			8'd15: r = 20'd201326; 8'd16: r = 20'd2350;   8'd17: r = 20'd465197;
			8'd18: r = 20'd3221;   8'd19: r = 20'd3402;   8'd20: r = 20'd400202;
			8'd21: r = 20'd2901;   8'd22: r = 20'd1386;   8'd23: r = 20'd267611;
			8'd24: r = 20'd605;    8'd25: r = 20'd2349;   8'd26: r = 20'd137515;
			8'd27: r = 20'd2709;   8'd28: r = 20'd464533; 8'd29: r = 20'd1738;
			8'd30: r = 20'd2901;   8'd31: r = 20'd330421; 8'd32: r = 20'd1242;
			8'd33: r = 20'd2651;   8'd34: r = 20'd199255; 8'd35: r = 20'd1323;
			8'd36: r = 20'd529706; 8'd37: r = 20'd3733;   8'd38: r = 20'd1706;
			8'd39: r = 20'd398762; 8'd40: r = 20'd2741;   8'd41: r = 20'd1206;
			8'd42: r = 20'd267438; 8'd43: r = 20'd2647;   8'd44: r = 20'd1318;
			8'd45: r = 20'd204070; 8'd46: r = 20'd3477;   8'd47: r = 20'd461653;
			8'd48: r = 20'd1386;   8'd49: r = 20'd2413;   8'd50: r = 20'd330077;
			8'd51: r = 20'd1197;   8'd52: r = 20'd2637;   8'd53: r = 20'd268877;
			8'd54: r = 20'd3365;   8'd55: r = 20'd531109; 8'd56: r = 20'd2900;
			8'd57: r = 20'd2922;   8'd58: r = 20'd398042; 8'd59: r = 20'd2395;
			8'd60: r = 20'd1179;   8'd61: r = 20'd267415; 8'd62: r = 20'd2635;
			8'd63: r = 20'd661067; 8'd64: r = 20'd1701;   8'd65: r = 20'd1748;
			8'd66: r = 20'd398772; 8'd67: r = 20'd2742;   8'd68: r = 20'd2391;
			8'd69: r = 20'd330031; 8'd70: r = 20'd1175;   8'd71: r = 20'd1611;
			8'd72: r = 20'd200010; 8'd73: r = 20'd3749;   8'd74: r = 20'd527717;
			8'd75: r = 20'd1452;   8'd76: r = 20'd2742;   8'd77: r = 20'd332397;
			8'd78: r = 20'd2350;   8'd79: r = 20'd3222;   8'd80: r = 20'd268949;
			8'd81: r = 20'd3402;   8'd82: r = 20'd3493;   8'd83: r = 20'd133973;
			8'd84: r = 20'd1386;   8'd85: r = 20'd464219; 8'd86: r = 20'd605;
			8'd87: r = 20'd2349;   8'd88: r = 20'd334123; 8'd89: r = 20'd2709;
			8'd90: r = 20'd2890;   8'd91: r = 20'd267946; 8'd92: r = 20'd2773;
			8'd93: r = 20'd592565; 8'd94: r = 20'd1210;   8'd95: r = 20'd2651;
			8'd96: r = 20'd395863; 8'd97: r = 20'd1323;   8'd98: r = 20'd2707;
			8'd99: r = 20'd265877;
			default: r = 20'd0;
		endcase
		return r;
	endfunction

endpackage

>>> src/gld_day_count.sv
// Day count from the first lunar day of 1921, leap every fourth year.
module gld_day_count (
	input  logic [gld_pkg::YEAR_W-1:0]         year,
	input  logic [gld_pkg::MONTH_W-1:0]        month,
	input  logic [gld_pkg::DAY_W-1:0]          day,
	output logic signed [gld_pkg::COUNT_W-1:0] count,
	output logic                               month_bad
);
	import gld_pkg::*;

	logic signed [12:0]        yfb;
	logic signed [COUNT_W-1:0] yfb_x;
	logic signed [COUNT_W-1:0] year_days;
	logic signed [COUNT_W-1:0] quad_days;
	logic                      leap_adj;

	// Years from the base; the arithmetic shift gives a floor division by four.
	assign yfb       = $signed({2'b00, year}) - 13'sd1921;
	assign yfb_x     = COUNT_W'(yfb);
	assign year_days = yfb_x * COUNT_W'(DAYS_PER_YEAR);
	assign quad_days = COUNT_W'(yfb >>> 2);
	assign leap_adj  = (year[1:0] == 2'b00) && (month > 4'd2);

	// Sum the pieces into a signed count that is 1 on the base date.
	assign count = year_days + quad_days
	             + $signed(COUNT_W'(day))
	             + $signed(COUNT_W'(month_start(month)))
	             - COUNT_W'(BASE_OFFSET)
	             + $signed(COUNT_W'(leap_adj));

	assign month_bad = (month < 4'd1) || (month > 4'd12);

endmodule

>>> src/gregorian_to_lunar_date.sv
// Top level: Gregorian to Chinese lunar date converter with a month-walk sequencer.
// The request is taken in idle, the count is checked, and then the month walk, one
// compare-and-subtract per cycle against the month ROM, steps through the lunar
// months from 1921 until the remaining days fit or the table ends.
// Throughput: one request at a time; busy is high until the result strobe.
// Results are valid on the result ports when done is high for a single cycle, and held until the next result.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and clears done.
module gregorian_to_lunar_date #(
	parameter int TABLE_YEARS = gld_pkg::TABLE_YEARS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [gld_pkg::YEAR_W-1:0]    gregorian_year,
	input  logic [gld_pkg::MONTH_W-1:0]   gregorian_month,
	input  logic [gld_pkg::DAY_W-1:0]     gregorian_day,
	output logic                          done,
	output logic [gld_pkg::YEAR_W-1:0]    lunar_year,
	output logic [gld_pkg::MONTH_W-1:0]   lunar_month,
	output logic                          is_leap_month,
	output logic [gld_pkg::DAY_W-1:0]     lunar_day,
	output logic [gld_pkg::IDX4_W-1:0]    stem_index,
	output logic [gld_pkg::IDX4_W-1:0]    branch_index,
	output logic                          out_of_range
);
	import gld_pkg::*;

	localparam int IDX_W = (TABLE_YEARS > 1) ? $clog2(TABLE_YEARS + 1) : 1;
	localparam int LIMIT = (TABLE_YEARS < ROM_YEARS) ? TABLE_YEARS : ROM_YEARS;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;

	logic [1:0]                state_q;
	logic signed [COUNT_W-1:0] count_in;
	logic                      month_bad_in;
	logic signed [COUNT_W-1:0] count_q;
	logic                      month_bad_q;
	logic [WALK_W-1:0]         walk_q;
	logic [IDX_W-1:0]          idx_q;
	logic [IDX_W-1:0]          idx_next;
	logic [ENTRY_W-1:0]        entry_q;
	logic [ENTRY_W-1:0]        entry_next;
	logic [3:0]                pos_q;
	logic [IDX4_W-1:0]         stem_q;
	logic [IDX4_W-1:0]         branch_q;
	logic [3:0]                top;
	logic [3:0]                top_next;
	logic [4:0]                month_len;
	logic                      fits;
	logic [3:0]                month_raw;
	logic [3:0]                leap_at;
	logic [3:0]                month_fix;
	logic                      leap_hit;
	logic                      done_q;
	logic [YEAR_W-1:0]         lyear_q;
	logic [MONTH_W-1:0]        lmonth_q;
	logic                      leap_q;
	logic [DAY_W-1:0]          lday_q;
	logic [IDX4_W-1:0]         stem_out_q;
	logic [IDX4_W-1:0]         branch_out_q;
	logic                      oor_q;

	gld_day_count u_count (
		.year      (gregorian_year),
		.month     (gregorian_month),
		.day       (gregorian_day),
		.count     (count_in),
		.month_bad (month_bad_in)
	);

	// Month length of the current bit and the shared compare against the remaining days.
	assign top        = (entry_q >= ENTRY_W'(LONG_YEAR_MIN)) ? TOP_LONG : TOP_SHORT;
	assign idx_next   = idx_q + 1'b1;
	assign entry_next = lunar_rom(ROM_IDX_W'(idx_next));
	assign top_next   = (entry_next >= ENTRY_W'(LONG_YEAR_MIN)) ? TOP_LONG : TOP_SHORT;
	assign month_len  = 5'(SHORT_MONTH) + 5'(entry_q[pos_q]);
	assign fits       = (walk_q <= WALK_W'(month_len));

	// Month number and leap flag of the month the walk stopped in.
	assign month_raw = top - pos_q + 4'd1;
	assign leap_at   = entry_q[19:16] + 4'd1;
	always_comb begin
		leap_hit  = 1'b0;
		month_fix = month_raw;
		if (top == TOP_LONG) begin
			if (month_raw == leap_at) begin
				leap_hit  = 1'b1;
				month_fix = month_raw - 4'd1;
			end else if (month_raw > leap_at) begin
				month_fix = month_raw - 4'd1;
			end
		end
	end

	// Sequencer: take the request, check the count and stop if it is bad, else walk one month per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (month_bad_q || (count_q <= $signed(COUNT_W'(0)))) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (fits) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else if ((pos_q == 4'd0) && (idx_next == IDX_W'(LIMIT))) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the walk and the result.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					count_q     <= count_in;
					month_bad_q <= month_bad_in;
				end
			end
			ST_CHECK: begin
				walk_q   <= count_q[WALK_W-1:0];
				idx_q    <= '0;
				entry_q  <= lunar_rom(ROM_IDX_W'(0));
				pos_q    <= (lunar_rom(ROM_IDX_W'(0)) >= ENTRY_W'(LONG_YEAR_MIN)) ?
				            TOP_LONG : TOP_SHORT;
				stem_q   <= STEM_BASE;
				branch_q <= BRANCH_BASE;
				if (month_bad_q || (count_q <= $signed(COUNT_W'(0)))) begin
					lyear_q      <= '0;
					lmonth_q     <= '0;
					leap_q       <= 1'b0;
					lday_q       <= '0;
					stem_out_q   <= '0;
					branch_out_q <= '0;
					oor_q        <= 1'b1;
				end
			end
			ST_WALK: begin
				if (fits) begin
					lyear_q      <= YEAR_W'(BASE_YEAR) + YEAR_W'(idx_q);
					lmonth_q     <= month_fix;
					leap_q       <= leap_hit;
					lday_q       <= walk_q[DAY_W-1:0];
					stem_out_q   <= stem_q;
					branch_out_q <= branch_q;
					oor_q        <= 1'b0;
				end else begin
					walk_q <= walk_q - WALK_W'(month_len);
					if (pos_q == 4'd0) begin
						if (idx_next == IDX_W'(LIMIT)) begin
							lyear_q      <= '0;
							lmonth_q     <= '0;
							leap_q       <= 1'b0;
							lday_q       <= '0;
							stem_out_q   <= '0;
							branch_out_q <= '0;
							oor_q        <= 1'b1;
						end else begin
							idx_q    <= idx_next;
							entry_q  <= entry_next;
							pos_q    <= top_next;
							stem_q   <= (stem_q == STEM_LAST) ? '0 : stem_q + 4'd1;
							branch_q <= (branch_q == BRANCH_LAST) ? '0 : branch_q + 4'd1;
						end
					end else begin
						pos_q <= pos_q - 4'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign lunar_year    = lyear_q;
	assign lunar_month   = lmonth_q;
	assign is_leap_month = leap_q;
	assign lunar_day     = lday_q;
	assign stem_index    = stem_out_q;
	assign branch_index  = branch_out_q;
	assign out_of_range  = oor_q;

endmodule

>>> src/gld_checker.sv
// Port-level checker for the lunar date converter, bound to the top level.
module gld_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [gld_pkg::YEAR_W-1:0]  lunar_year,
	input logic [gld_pkg::MONTH_W-1:0] lunar_month,
	input logic                        is_leap_month,
	input logic [gld_pkg::DAY_W-1:0]   lunar_day,
	input logic [gld_pkg::IDX4_W-1:0]  stem_index,
	input logic [gld_pkg::IDX4_W-1:0]  branch_index,
	input logic                        out_of_range
);
	import gld_pkg::*;

	// An accepted request makes the block busy in the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	// The result strobe comes exactly when busy drops.
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// A result is only shown once the block is idle again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// A flagged result carries all other fields as zero.
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_range |-> (lunar_year == '0) && (lunar_month == '0) &&
		!is_leap_month && (lunar_day == '0) && (stem_index == '0) &&
		(branch_index == '0))
		else $error("out-of-range result with nonzero fields");

	// A converted date has a sane month, day, stem and branch.
	a_ok_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		done && !out_of_range |-> (lunar_month >= 4'd1) && (lunar_month <= 4'd12) &&
		(lunar_day >= 5'd1) && (lunar_day <= 5'd30) && (stem_index <= 4'd9) &&
		(branch_index <= 4'd11))
		else $error("converted result out of its field ranges");

endmodule

bind gregorian_to_lunar_date gld_checker u_gld_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.lunar_year    (lunar_year),
	.lunar_month   (lunar_month),
	.is_leap_month (is_leap_month),
	.lunar_day     (lunar_day),
	.stem_index    (stem_index),
	.branch_index  (branch_index),
	.out_of_range  (out_of_range)
);
